### sv/mnma_pkg.sv
// Shared constants, field widths and control types for the nonzero moving average unit.
`timescale 1ns / 1ps

package mnma_pkg;

	// Sizing of the filter.
	localparam int CHANNELS    = 6;
	localparam int WINDOW      = 11;
	localparam int SAMPLE_BITS = 16;

	// Fixed widths of the stream fields.
	localparam int CHAN_W    = 3;
	localparam int SAMPLE_W  = 16;
	localparam int AVG_W     = 16;
	localparam int S_FIELD_W = CHAN_W + SAMPLE_W;
	localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((AVG_W + 7) / 8) * 8;

	// Derived storage widths.
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int POS_W    = $clog2(WINDOW);
	localparam int CNT_W    = $clog2(WINDOW + 1);
	localparam int SUM_W    = SAMPLE_BITS + $clog2(WINDOW);
	localparam int DEPTH    = CHANNELS * WINDOW;
	localparam int ADDR_W   = $clog2(DEPTH);

	// Radix-2 restoring divider, several quotient bits per cycle.
	localparam int DIV_STEPS  = 5;
	localparam int DIV_CYCLES = (SUM_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int DIV_BITS   = DIV_CYCLES * DIV_STEPS;
	localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // input word taken, look up channel state
		logic calc;      // update the window and load the divider
		logic div_step;  // one divider iteration
		logic load_out;  // move the quotient into the output register
	} mnma_cmd_t;

endpackage

### sv/mnma_div.sv
// Multi-cycle restoring divider for the window sum over the entry count.
`timescale 1ns / 1ps

module mnma_div
	import mnma_pkg::*;
(
	input  logic                clk,
	input  logic                load,
	input  logic                step,
	input  logic [SUM_W-1:0]    dividend,
	input  logic [CNT_W-1:0]    divisor,
	output logic [SUM_W-1:0]    quotient
);

	logic [DIV_BITS-1:0] quo_q;
	logic [CNT_W-1:0]    rem_q;
	logic [CNT_W-1:0]    dvs_q;
	logic [DIV_BITS-1:0] quo_nxt;
	logic [CNT_W-1:0]    rem_nxt;

	// The quotient register doubles as the dividend shift register.
	always_comb begin
		logic [CNT_W:0] trial;
		quo_nxt = quo_q;
		rem_nxt = rem_q;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial = {rem_nxt, quo_nxt[DIV_BITS-1]};
			if (trial >= {1'b0, dvs_q}) begin
				rem_nxt = CNT_W'(trial - {1'b0, dvs_q});
				quo_nxt = {quo_nxt[DIV_BITS-2:0], 1'b1};
			end else begin
				rem_nxt = trial[CNT_W-1:0];
				quo_nxt = {quo_nxt[DIV_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			quo_q <= DIV_BITS'(dividend);
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (step) begin
			quo_q <= quo_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign quotient = quo_q[SUM_W-1:0];

endmodule

### sv/mnma_dp.sv
// Datapath: window store, per-channel running state, divider and output register.
`timescale 1ns / 1ps

module mnma_dp
	import mnma_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  mnma_cmd_t            cmd,
	input  logic [CHAN_W-1:0]    chan,
	input  logic [SAMPLE_W-1:0]  sample,
	output logic [AVG_W-1:0]     average
);

	// Window store, one ring of WINDOW entries per channel.
	logic [SAMPLE_BITS-1:0] mem_q [0:DEPTH-1];

	// Per-channel state. A ring whose position has never wrapped holds
	// unwritten entries at and beyond its position, which read as zero.
	logic [POS_W-1:0] pos_q     [0:CHANNELS-1];
	logic [SUM_W-1:0] sum_q     [0:CHANNELS-1];
	logic [CNT_W-1:0] cnt_q     [0:CHANNELS-1];
	logic             wrapped_q [0:CHANNELS-1];

	// Lookup stage.
	logic [CH_IDX_W-1:0]    ch_s1;
	logic                   in_range_s1;
	logic [SAMPLE_BITS-1:0] smp_s1;
	logic [ADDR_W-1:0]      addr_s1;
	logic [POS_W-1:0]       pos_s1;
	logic [SUM_W-1:0]       sum_s1;
	logic [CNT_W-1:0]       cnt_s1;
	logic                   wrapped_s1;
	logic [SAMPLE_BITS-1:0] rdata_s1;

	logic [AVG_W-1:0] avg_q;

	logic [CH_IDX_W-1:0]    ch_idx;
	logic                   in_range;
	logic [ADDR_W-1:0]      rd_addr;
	logic [SAMPLE_BITS-1:0] oldest;
	logic [CNT_W-1:0]       kept;
	logic [SUM_W-1:0]       new_sum;
	logic [CNT_W-1:0]       new_cnt;
	logic                   last_pos;
	logic [POS_W-1:0]       next_pos;
	logic [SUM_W-1:0]       div_dividend;
	logic [CNT_W-1:0]       div_divisor;
	logic [SUM_W-1:0]       quotient;

	assign ch_idx   = CH_IDX_W'(chan);
	assign in_range = (int'(chan) < CHANNELS);
	assign rd_addr  = in_range ? (ADDR_W'(ch_idx) * ADDR_W'(WINDOW) + ADDR_W'(pos_q[ch_idx]))
	                           : '0;

	always_comb begin
		oldest   = wrapped_s1 ? rdata_s1 : '0;
		kept     = cnt_s1 - CNT_W'(oldest != '0);
		new_sum  = sum_s1 - SUM_W'(oldest) + SUM_W'(smp_s1);
		new_cnt  = kept + CNT_W'(smp_s1 != '0);
		last_pos = (pos_s1 == POS_W'(WINDOW - 1));
		next_pos = last_pos ? '0 : pos_s1 + POS_W'(1);
		div_dividend = in_range_s1 ? new_sum : '0;
		div_divisor  = in_range_s1 ? kept + CNT_W'(1) : CNT_W'(1);
	end

	// Window store port: read on capture, write on update.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rdata_s1 <= mem_q[rd_addr];
		end
		if (cmd.calc && in_range_s1) begin
			mem_q[addr_s1] <= smp_s1;
		end
	end

	// Lookup stage payload.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ch_s1       <= ch_idx;
			in_range_s1 <= in_range;
			smp_s1      <= SAMPLE_BITS'(sample);
			addr_s1     <= rd_addr;
			pos_s1      <= in_range ? pos_q[ch_idx] : '0;
			sum_s1      <= in_range ? sum_q[ch_idx] : '0;
			cnt_s1      <= in_range ? cnt_q[ch_idx] : '0;
			wrapped_s1  <= in_range ? wrapped_q[ch_idx] : 1'b0;
		end
	end

	// Per-channel running state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				pos_q[c]     <= '0;
				sum_q[c]     <= '0;
				cnt_q[c]     <= '0;
				wrapped_q[c] <= 1'b0;
			end
		end else if (cmd.calc && in_range_s1) begin
			pos_q[ch_s1] <= next_pos;
			sum_q[ch_s1] <= new_sum;
			cnt_q[ch_s1] <= new_cnt;
			if (last_pos) begin
				wrapped_q[ch_s1] <= 1'b1;
			end
		end
	end

	mnma_div u_div (
		.clk      (clk),
		.load     (cmd.calc),
		.step     (cmd.div_step),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			avg_q <= AVG_W'(quotient[SAMPLE_BITS-1:0]);
		end
	end

	assign average = avg_q;

endmodule

### sv/mnma_ctrl.sv
// Controller: sequences lookup, update, division and the output handshake.
`timescale 1ns / 1ps

module mnma_ctrl
	import mnma_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output mnma_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t               state_q;
	logic [DIV_CNT_W-1:0] step_q;
	logic                 out_valid_q;

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		cmd.capture  = in_valid && in_ready;
		cmd.calc     = (state_q == ST_CALC);
		cmd.div_step = (state_q == ST_DIV);
		cmd.load_out = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result may replace one that leaves at the same edge.
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + DIV_CNT_W'(1);
					if (step_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (cmd.load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

### sv/multichannel_nonzero_moving_average_unit.sv
// Top level of the multichannel nonzero moving average unit.
// A word is taken only while the controller is idle. It then passes through the
// lookup, the update and the four iterations of the shared divider (five quotient
// bits per iteration), and the next word is taken once its result is loaded out.
// The output register lets the next word in while a result still waits.
// Reset (arst_n low) empties every channel at once; no clearing pass is run.
`timescale 1ns / 1ps

module multichannel_nonzero_moving_average_unit
	import mnma_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Input stream: one sample word for one channel.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // [2:0] chan, [18:3] sample, rest zero
	// Output stream: one average word per input word.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata   // [15:0] average
);

	// The controller decides when each word moves and which datapath step
	// runs; the datapath holds every piece of stored data. They talk only
	// through the command struct below.
	mnma_cmd_t         cmd;
	logic [AVG_W-1:0]  average;

	mnma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	// A channel number beyond the last channel leaves all state untouched
	// and produces an average of zero, as it divides zero by one.
	mnma_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.chan    (s_tdata[CHAN_W-1:0]),
		.sample  (s_tdata[S_FIELD_W-1:CHAN_W]),
		.average (average)
	);

	assign m_tdata = M_TDATA_W'(average);

endmodule

### sim/nonzero_average_checker.sv
// Checker that predicts and compares every average word of the nonzero moving average unit.
`timescale 1ns / 1ps

module nonzero_average_checker
	import mnma_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,
	output int unsigned          failures,
	output int unsigned          pending
);

	// Private copy of every channel's window.
	logic [SAMPLE_BITS-1:0] window_samples [CHANNELS][WINDOW];
	logic [POS_W-1:0]       oldest_slot    [CHANNELS];
	logic [SUM_W-1:0]       window_sum     [CHANNELS];
	logic [CNT_W-1:0]       filled_count   [CHANNELS];

	logic [AVG_W-1:0] expected_averages [$];

	initial begin
		failures = 0;
		pending  = 0;
	end

	// Pushes one sample into its channel's window and returns the average it yields.
	function automatic logic [AVG_W-1:0] predict_average(input logic [CHAN_W-1:0]   chan,
	                                                     input logic [SAMPLE_W-1:0] sample);
		logic [SAMPLE_BITS-1:0] fresh;
		logic [SAMPLE_BITS-1:0] dropped;
		logic [SUM_W-1:0]       new_sum;
		logic [CNT_W-1:0]       kept;
		int unsigned            ch;
		int unsigned            slot;
		int unsigned            quotient;
		fresh = sample[SAMPLE_BITS-1:0];
		if (chan >= CHANNELS)
			return '0;
		ch   = chan;
		slot = oldest_slot[ch];
		if (slot >= WINDOW)
			slot = 0;
		dropped = window_samples[ch][slot];
		new_sum = window_sum[ch] - dropped + fresh;
		kept    = filled_count[ch] - CNT_W'(dropped != '0);
		window_samples[ch][slot] = fresh;
		window_sum[ch]   = new_sum;
		filled_count[ch] = kept + CNT_W'(fresh != '0);
		oldest_slot[ch]  = (slot == WINDOW - 1) ? '0 : POS_W'(slot + 1);
		quotient = 32'(new_sum) / (32'(kept) + 32'd1);
		return AVG_W'(quotient[SAMPLE_BITS-1:0]);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [AVG_W-1:0] actual;
		logic [AVG_W-1:0] wanted;
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				for (int w = 0; w < WINDOW; w++)
					window_samples[c][w] = '0;
				oldest_slot[c]  = '0;
				window_sum[c]   = '0;
				filled_count[c] = '0;
			end
			expected_averages.delete();
			pending = 0;
		end else begin
			// The result leaving now always belongs to an older input word,
			// so it is compared before this edge's input word is predicted.
			if (m_tvalid && m_tready) begin
				actual = m_tdata[AVG_W-1:0];
				if (expected_averages.size() == 0) begin
					$error("average word with no expectation: actual %0d", actual);
					failures++;
				end else begin
					wanted = expected_averages.pop_front();
					if (actual !== wanted) begin
						$error("average mismatch: expected %0d, actual %0d", wanted, actual);
						failures++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_averages.push_back(predict_average(s_tdata[CHAN_W-1:0],
				                                            s_tdata[CHAN_W +: SAMPLE_W]));
			pending = expected_averages.size();
		end
	end

endmodule

### sim/multichannel_nonzero_moving_average_unit_tb.sv
// Testbench top that drives sample words into the nonzero moving average unit and gives the verdict.
`timescale 1ns / 1ps

module multichannel_nonzero_moving_average_unit_tb;
	import mnma_pkg::*;

	// Generous bound, well above the slowest expected run.
	localparam int CYCLE_LIMIT     = 400000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 20;
	localparam int PHASE_ITEMS     = 500;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;

	int unsigned failures;
	int unsigned pending;
	int unsigned cycle_count;

	// Percentages of cycles in which each side idles; changed between phases.
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	// Once armed, the receiver withholds tready for a long stretch so that
	// the unit fills up and stalls its input while words keep being offered.
	bit          hold_off_armed;
	int unsigned hold_cycles;

	multichannel_nonzero_moving_average_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	nonzero_average_checker average_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.failures(failures),
		.pending (pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Run guard: a hung handshake ends the run as a failure.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	// Receiver: random back-pressure, plus the single long hold-off when armed.
	initial begin
		m_tready    = 1'b0;
		hold_cycles = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_armed && hold_cycles < HOLD_OFF_CYCLES) begin
				m_tready <= 1'b0;
				hold_cycles++;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offers one sample word, idling beforehand at random, and returns once it is taken.
	// Changes happen at the falling edge; tready is sampled at the rising edge.
	task automatic send_sample(input logic [CHAN_W-1:0] chan, input logic [SAMPLE_W-1:0] sample);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_TDATA_W'({sample, chan});
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
	endtask

	// Sample values weighted towards zero (an unfilled slot), the full-scale
	// value and small readings, the rest uniform over all sixteen bits.
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 20)
			return '0;
		else if (roll < 25)
			return '1;
		else if (roll < 32)
			return SAMPLE_W'($urandom_range(15, 1));
		else
			return SAMPLE_W'($urandom);
	endfunction

	// Sends random words until the phase's quota is reached. Most words come in
	// bursts on one valid channel so that windows fill and wrap; a few name a
	// channel that does not exist.
	task automatic send_random_phase(input int unsigned count);
		int unsigned            sent;
		int unsigned            burst;
		logic [CHAN_W-1:0]      chan;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 4) begin
				chan  = CHAN_W'($urandom_range(7, CHANNELS));
				burst = 1;
			end else begin
				chan  = CHAN_W'($urandom_range(CHANNELS - 1));
				burst = $urandom_range(16, 1);
			end
			for (int i = 0; i < burst && sent < count; i++) begin
				send_sample(chan, pick_sample());
				sent++;
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		hold_off_armed = 1'b0;
		send_idle_pct  = 7;
		recv_idle_pct  = 51;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Directed words. Channels that do not exist must read back zero and
		// leave every window alone.
		send_sample(3'd7, 16'hFFFF);
		send_sample(3'd6, 16'h5A5A);
		// A zero sample into an empty window, then a full-scale one.
		send_sample(3'd0, 16'h0000);
		send_sample(3'd0, 16'hFFFF);
		// Full-scale samples past the window depth: largest sum, ring wrap.
		repeat (WINDOW + 1)
			send_sample(3'd1, 16'hFFFF);
		// Zeros between readings do not count towards the divisor.
		send_sample(3'd2, 16'h0000);
		send_sample(3'd2, 16'd100);
		send_sample(3'd2, 16'h0000);
		send_sample(3'd2, 16'd7);
		send_sample(3'd5, 16'd1);
		send_sample(3'd3, 16'hAAAA);
		send_sample(3'd4, 16'h5555);

		// Sender rarely idles, receiver often stalls.
		send_random_phase(PHASE_ITEMS);

		send_idle_pct = 51;
		recv_idle_pct = 7;
		send_random_phase(PHASE_ITEMS);

		// Neither side idles, apart from the one long receiver hold-off.
		send_idle_pct  = 0;
		recv_idle_pct  = 0;
		hold_off_armed = 1'b1;
		send_random_phase(PHASE_ITEMS);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		// Allow for a stray word that the unit might still produce.
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
